// File: rtl/tpg_pkg.sv
`timescale 1ns / 1ps

package tpg_pkg;

	localparam int VISIBLE_COLUMNS_DEF = 26;
	localparam int TILE_ROM_BYTES      = 8192;
	localparam int PROM_BYTES          = 512;
	localparam int TILE_RAM_BYTES      = 1024;
	localparam int PLANE_BYTES         = TILE_ROM_BYTES / 2;
	localparam int PROM_HALF_BYTES     = PROM_BYTES / 2;

	localparam int ROM_AW   = $clog2(TILE_ROM_BYTES);
	localparam int PLANE_AW = $clog2(PLANE_BYTES);
	localparam int PROM_AW  = $clog2(PROM_BYTES);
	localparam int HALF_AW  = $clog2(PROM_HALF_BYTES);
	localparam int RAM_AW   = $clog2(TILE_RAM_BYTES);

	localparam logic CFG_PALETTE_SELECT = 1'b0;
	localparam logic CFG_SCROLL_OFFSET  = 1'b1;

	typedef enum logic [2:0] {
		KIND_TILE_ROM = 3'd0,
		KIND_PROM     = 3'd1,
		KIND_FG_RAM   = 3'd2,
		KIND_BG_RAM   = 3'd3,
		KIND_QUERY    = 3'd4
	} kind_t;

endpackage

// File: rtl/tilemap_pixel_generator.sv
`timescale 1ns / 1ps

// Words run through register stages s1 to s4; out_valid is driven by s4 for
// queries only. One word per cycle unless out_stall holds the pipeline; tile
// RAM, tile ROM and palette PROM reads are chained through four register stages,
// each memory read at its own stage edge. Write words update each memory as
// they pass that memory's read stage. Reset (arst_n low, asynchronous) clears
// valid bits and both control registers; memory contents stay undefined until written.
module tilemap_pixel_generator
	import tpg_pkg::*;
#(
	parameter int VISIBLE_COLUMNS = VISIBLE_COLUMNS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [12:0] address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        from_foreground
);

	logic       palette_select_q;
	logic [7:0] scroll_offset_q;

	logic [7:0] fg_ram [TILE_RAM_BYTES];
	logic [7:0] bg_ram [TILE_RAM_BYTES];
	logic [7:0] plane0 [PLANE_BYTES];
	logic [7:0] plane1 [PLANE_BYTES];
	logic [7:0] prom_lo [PROM_HALF_BYTES];
	logic [7:0] prom_hi [PROM_HALF_BYTES];

	logic rdy1, rdy2, rdy3, rdy4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	// stage 1
	logic [2:0]        kind_s1;
	logic              vis_s1;
	logic [2:0]        xl_s1;
	logic [2:0]        fg_bit_s1, bg_bit_s1;
	logic [ROM_AW-1:0] addr_s1;
	logic [7:0]        data_s1;
	logic [7:0]        fg_code_s1, bg_code_s1;

	// stage 2
	logic [2:0]         kind_s2;
	logic               vis_s2;
	logic [2:0]         fg_bit_s2, bg_bit_s2;
	logic [2:0]         fg_pal_s2, bg_pal_s2;
	logic [PROM_AW-1:0] addr_s2;
	logic [7:0]         data_s2;
	logic [7:0]         fg_p0_s2, fg_p1_s2, bg_p0_s2, bg_p1_s2;

	// stage 3
	logic [2:0] kind_s3;
	logic       vis_s3;
	logic [7:0] fg_lo_s3, fg_hi_s3, bg_lo_s3, bg_hi_s3;

	// stage 4
	logic [7:0] red_s4, green_s4, blue_s4;
	logic       fg_s4;

	logic              accept;
	logic [4:0]        col;
	logic              vis;
	logic [7:0]        bg_row;
	logic [RAM_AW-1:0] fg_idx, bg_idx;
	logic [4:0]        col_flip;

	logic [PLANE_AW-1:0] fg_rom_addr, bg_rom_addr;
	logic [HALF_AW-1:0]  fg_prom_addr, bg_prom_addr;
	logic                fg_p0, fg_p1, bg_p0, bg_p1;

	logic [1:0] fg_r, fg_g, fg_b, bg_r, bg_g, bg_b, sel_r, sel_g, sel_b;
	logic       fg_shown;

	assign rdy4     = !valid_s4 || !out_stall;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;
	assign accept   = in_valid && rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_select_q <= 1'b0;
			scroll_offset_q  <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PALETTE_SELECT: palette_select_q <= cfg_data[0];
				CFG_SCROLL_OFFSET:  scroll_offset_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		col      = pixel_x[7:3];
		vis      = {1'b0, col} < 6'(VISIBLE_COLUMNS);
		col_flip = 5'(VISIBLE_COLUMNS - 1) - col;
		bg_row   = pixel_y + scroll_offset_q;
		fg_idx   = {col_flip, pixel_y[7:3]};
		bg_idx   = {col_flip, bg_row[7:3]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= in_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3 && (kind_s3 == KIND_QUERY);
			end
		end
	end

	// tile RAMs: written and read as the word enters
	always_ff @(posedge clk) begin
		if (accept) begin
			if (kind == KIND_FG_RAM) begin
				fg_ram[address[RAM_AW-1:0]] <= write_data;
			end
			if (kind == KIND_BG_RAM) begin
				bg_ram[address[RAM_AW-1:0]] <= write_data;
			end
			fg_code_s1 <= fg_ram[fg_idx];
			bg_code_s1 <= bg_ram[bg_idx];
			kind_s1    <= kind;
			vis_s1     <= vis;
			xl_s1      <= pixel_x[2:0];
			fg_bit_s1  <= pixel_y[2:0];
			bg_bit_s1  <= bg_row[2:0];
			addr_s1    <= address;
			data_s1    <= write_data;
		end
	end

	assign fg_rom_addr = {1'b0, fg_code_s1, ~xl_s1};
	assign bg_rom_addr = {1'b1, bg_code_s1, ~xl_s1};

	// tile ROM bitplanes
	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			if (kind_s1 == KIND_TILE_ROM) begin
				if (addr_s1[ROM_AW-1]) begin
					plane1[addr_s1[PLANE_AW-1:0]] <= data_s1;
				end else begin
					plane0[addr_s1[PLANE_AW-1:0]] <= data_s1;
				end
			end
			fg_p0_s2  <= plane0[fg_rom_addr];
			fg_p1_s2  <= plane1[fg_rom_addr];
			bg_p0_s2  <= plane0[bg_rom_addr];
			bg_p1_s2  <= plane1[bg_rom_addr];
			kind_s2   <= kind_s1;
			vis_s2    <= vis_s1;
			fg_bit_s2 <= fg_bit_s1;
			bg_bit_s2 <= bg_bit_s1;
			fg_pal_s2 <= fg_code_s1[7:5];
			bg_pal_s2 <= bg_code_s1[7:5];
			addr_s2   <= addr_s1[PROM_AW-1:0];
			data_s2   <= data_s1;
		end
	end

	always_comb begin
		fg_p0        = fg_p0_s2[fg_bit_s2];
		fg_p1        = fg_p1_s2[fg_bit_s2];
		bg_p0        = bg_p0_s2[bg_bit_s2];
		bg_p1        = bg_p1_s2[bg_bit_s2];
		fg_prom_addr = {1'b0, palette_select_q, 1'b1, fg_p1, fg_p0, fg_pal_s2};
		bg_prom_addr = {1'b0, palette_select_q, 1'b0, bg_p1, bg_p0, bg_pal_s2};
	end

	// palette PROM pair
	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			if (kind_s2 == KIND_PROM) begin
				if (addr_s2[PROM_AW-1]) begin
					prom_hi[addr_s2[HALF_AW-1:0]] <= data_s2;
				end else begin
					prom_lo[addr_s2[HALF_AW-1:0]] <= data_s2;
				end
			end
			fg_lo_s3 <= prom_lo[fg_prom_addr];
			fg_hi_s3 <= prom_hi[fg_prom_addr];
			bg_lo_s3 <= prom_lo[bg_prom_addr];
			bg_hi_s3 <= prom_hi[bg_prom_addr];
			kind_s3  <= kind_s2;
			vis_s3   <= vis_s2;
		end
	end

	always_comb begin
		fg_r     = {fg_hi_s3[0], fg_lo_s3[0]};
		fg_b     = {fg_hi_s3[1], fg_lo_s3[1]};
		fg_g     = {fg_hi_s3[2], fg_lo_s3[2]};
		bg_r     = {bg_hi_s3[0], bg_lo_s3[0]};
		bg_b     = {bg_hi_s3[1], bg_lo_s3[1]};
		bg_g     = {bg_hi_s3[2], bg_lo_s3[2]};
		fg_shown = vis_s3 && ({fg_r, fg_g, fg_b} != 6'd0);
		if (!vis_s3) begin
			sel_r = 2'd0;
			sel_g = 2'd0;
			sel_b = 2'd0;
		end else if (fg_shown) begin
			sel_r = fg_r;
			sel_g = fg_g;
			sel_b = fg_b;
		end else begin
			sel_r = bg_r;
			sel_g = bg_g;
			sel_b = bg_b;
		end
	end

	// scale 2-bit level by 85: replicate the two bits
	always_ff @(posedge clk) begin
		if (rdy4 && valid_s3) begin
			red_s4   <= {4{sel_r}};
			green_s4 <= {4{sel_g}};
			blue_s4  <= {4{sel_b}};
			fg_s4    <= fg_shown;
		end
	end

	assign out_valid       = valid_s4;
	assign red             = red_s4;
	assign green           = green_s4;
	assign blue            = blue_s4;
	assign from_foreground = fg_s4;

	a_out_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		rdy4 |=> (out_valid == $past(valid_s3 && (kind_s3 == KIND_QUERY))))
		else $error("output valid does not follow a query");

	a_fg_not_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && from_foreground) |-> ((red | green | blue) != 8'd0))
		else $error("foreground shown with a black colour");

	a_level_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (red == {4{red[1:0]}} && green == {4{green[1:0]}} &&
			blue == {4{blue[1:0]}}))
		else $error("colour level is not a multiple of 85");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4))
		else $error("input stalled with a free stage");

endmodule
